// File: hw/rtl/plxy_pkg.sv
`timescale 1ns / 1ps

package plxy_pkg;

    localparam int TEMP_W              = 15;
    localparam int COORD_W             = 16;
    localparam int COORD_FRACTION_BITS = 16;
    localparam int U_FRAC              = 24;
    localparam int U_W                 = U_FRAC + 1;

    localparam logic [TEMP_W-1:0] T_MIN     = 15'd1000;
    localparam logic [TEMP_W-1:0] T_SPLIT_X = 15'd4000;
    localparam logic [TEMP_W-1:0] T_SPLIT_Y = 15'd2222;

    // 1000 * 2^24, reciprocal numerator
    localparam int                     DIV_NUM_W  = 34;
    localparam logic [DIV_NUM_W-1:0]   DIV_NUM    = 34'd1000 << U_FRAC;
    localparam int                     DIV_STAGES = U_W;

    localparam int COEF_W  = 31;
    localparam int PROD_W  = 2 * U_W;
    localparam int CPROD_W = COEF_W + U_W + 1;
    localparam int ACC_W   = 56;

    // divide-by-1e8 = shift by 8, then divide by 5^8 through a reciprocal
    localparam int                  COEF_SHIFT = 8;
    localparam int                  NQ_W       = 47;
    localparam int                  NQ_LO_W    = 24;
    localparam int                  NQ_HI_W    = NQ_W - NQ_LO_W;
    localparam int                  RECIP_W    = 32;
    localparam logic [RECIP_W-1:0]  RECIP_M    = 32'd2882303761;
    localparam int                  RECIP_SHIFT = 50;
    localparam int                  QE_SHIFT   = RECIP_SHIFT - NQ_LO_W;
    localparam int                  PH_W       = NQ_HI_W + RECIP_W;
    localparam int                  PL_W       = NQ_LO_W + RECIP_W;
    localparam int                  QSUM_W     = PL_W;
    localparam int                  Q_MAG_W    = 28;
    localparam int                  Q_W        = Q_MAG_W + 1;
    localparam int                  ODD_W      = 19;
    localparam logic [ODD_W-1:0]    SCALE_ODD  = 19'd390625;
    localparam int                  REM_LOW_W  = 21;
    localparam logic signed [ACC_W-1:0] HALF_SCALE = 56'sd50000000;

    localparam int CUBIC_STAGES = 11;

    localparam int ROUND_SHIFT = U_FRAC - COORD_FRACTION_BITS;
    localparam logic [Q_W:0] ROUND_HALF = ((Q_W + 1)'(1) << ROUND_SHIFT) >> 1;
    localparam logic [Q_W:0] COORD_MAX  = (Q_W + 1)'(16'hFFFF);

    typedef enum logic [2:0] {
        ROW_XA,
        ROW_XB,
        ROW_YA,
        ROW_YB,
        ROW_YC
    } coef_row_t;

    typedef enum logic [1:0] {
        COL_CUBE,
        COL_SQUARE,
        COL_LINEAR,
        COL_CONST
    } coef_col_t;

    typedef struct packed {
        logic valid;
        logic below_x_split;
        logic below_y_split;
    } tag_t;

    // coefficients in units of 1e-8
    function automatic logic signed [COEF_W-1:0] coef(coef_row_t row, coef_col_t col);
        logic signed [COEF_W-1:0] c_cube;
        logic signed [COEF_W-1:0] c_square;
        logic signed [COEF_W-1:0] c_linear;
        logic signed [COEF_W-1:0] c_const;
        case (row)
            ROW_XA:
            begin
                c_cube   = -31'sd26612390;
                c_square = -31'sd23435890;
                c_linear =  31'sd87769560;
                c_const  =  31'sd17991000;
            end
            ROW_XB:
            begin
                c_cube   = -31'sd302584690;
                c_square =  31'sd210703790;
                c_linear =  31'sd22263470;
                c_const  =  31'sd24039000;
            end
            ROW_YA:
            begin
                c_cube   = -31'sd110638140;
                c_square = -31'sd134811020;
                c_linear =  31'sd218555832;
                c_const  = -31'sd20219683;
            end
            ROW_YB:
            begin
                c_cube   = -31'sd95494760;
                c_square = -31'sd137418593;
                c_linear =  31'sd209137015;
                c_const  = -31'sd16748867;
            end
            ROW_YC:
            begin
                c_cube   =  31'sd308175800;
                c_square = -31'sd587338670;
                c_linear =  31'sd375112997;
                c_const  = -31'sd37001483;
            end
            default:
            begin
                c_cube   = '0;
                c_square = '0;
                c_linear = '0;
                c_const  = '0;
            end
        endcase
        case (col)
            COL_CUBE:   return c_cube;
            COL_SQUARE: return c_square;
            COL_LINEAR: return c_linear;
            COL_CONST:  return c_const;
            default:    return '0;
        endcase
    endfunction

    // Q24 signed to output fraction bits, rounded, clamped
    function automatic logic [COORD_W-1:0] to_coord(logic signed [Q_W-1:0] q);
        logic [Q_W:0] sum;
        logic [Q_W:0] scaled;
        sum    = {1'b0, q} + ROUND_HALF;
        scaled = sum >> ROUND_SHIFT;
        if (q < 0)
            return '0;
        else if (scaled > COORD_MAX)
            return '1;
        else
            return scaled[COORD_W-1:0];
    endfunction

endpackage

// File: hw/rtl/plxy_recip.sv
`timescale 1ns / 1ps

// u = round(1000 * 2^24 / t), restoring division, one quotient bit per stage
module plxy_recip (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic [plxy_pkg::TEMP_W-1:0]     temperature,
    output plxy_pkg::tag_t                  out_tag,
    output logic [plxy_pkg::U_W-1:0]        u
);

    localparam int STAGES = plxy_pkg::DIV_STAGES;
    localparam int TW     = plxy_pkg::TEMP_W;
    localparam int QW     = plxy_pkg::U_W;

    plxy_pkg::tag_t   tag_reg [0:STAGES];
    logic [TW-1:0]    den_reg [0:STAGES];
    logic [TW-1:0]    rem_reg [0:STAGES];
    logic [QW-1:0]    num_reg [0:STAGES];
    logic [QW-1:0]    quo_reg [0:STAGES];

    logic [TW-1:0]    rem_next [1:STAGES];
    logic             bit_next [1:STAGES];

    logic [TW-1:0]                      den_next;
    logic [plxy_pkg::DIV_NUM_W-1:0]     num_full;
    plxy_pkg::tag_t                     tag_next;

    always_comb
    begin
        den_next = (temperature < plxy_pkg::T_MIN) ? plxy_pkg::T_MIN : temperature;
        num_full = plxy_pkg::DIV_NUM + plxy_pkg::DIV_NUM_W'(den_next >> 1);
        tag_next.valid         = in_valid;
        tag_next.below_x_split = den_next < plxy_pkg::T_SPLIT_X;
        tag_next.below_y_split = den_next < plxy_pkg::T_SPLIT_Y;
    end

    always_comb
    begin : div_steps
        logic [TW:0] shifted;
        logic [TW:0] diff;
        for (int k = 1; k <= STAGES; k++)
        begin
            shifted     = {rem_reg[k-1], num_reg[k-1][QW-1]};
            diff        = shifted - {1'b0, den_reg[k-1]};
            bit_next[k] = shifted >= {1'b0, den_reg[k-1]};
            rem_next[k] = bit_next[k] ? diff[TW-1:0] : shifted[TW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
                tag_reg[k] <= '0;
        end
        else if (ce)
        begin
            tag_reg[0] <= tag_next;
            for (int k = 1; k <= STAGES; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg[0] <= den_next;
            rem_reg[0] <= TW'(num_full[plxy_pkg::DIV_NUM_W-1:QW]);
            num_reg[0] <= num_full[QW-1:0];
            quo_reg[0] <= '0;
            for (int k = 1; k <= STAGES; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= {num_reg[k-1][QW-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], bit_next[k]};
            end
        end
    end

    assign out_tag = tag_reg[STAGES];
    assign u       = quo_reg[STAGES];

endmodule

// File: hw/rtl/plxy_cubic.sv
`timescale 1ns / 1ps

// q = round((c3*v^3 + c2*v^2 + c1*v + c0) ), Q24 in and out, 11 stages
module plxy_cubic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                ce,
    input  plxy_pkg::tag_t                      in_tag,
    input  plxy_pkg::coef_row_t                 row,
    input  logic [plxy_pkg::U_W-1:0]            v,
    output plxy_pkg::tag_t                      out_tag,
    output logic signed [plxy_pkg::Q_W-1:0]     q
);

    localparam int NS    = plxy_pkg::CUBIC_STAGES;
    localparam int UW    = plxy_pkg::U_W;
    localparam int UF    = plxy_pkg::U_FRAC;
    localparam int PW    = plxy_pkg::PROD_W;
    localparam int AW    = plxy_pkg::ACC_W;
    localparam int CPW   = plxy_pkg::CPROD_W;
    localparam int NQW   = plxy_pkg::NQ_W;
    localparam int LOW   = plxy_pkg::NQ_LO_W;
    localparam int RLW   = plxy_pkg::REM_LOW_W;
    localparam int QMW   = plxy_pkg::Q_MAG_W;
    localparam int SHIFT = plxy_pkg::COEF_SHIFT;
    localparam logic [PW-1:0] ROUND_ONE = PW'(1) << (UF - 1);

    function automatic logic [UW-1:0] round_q(logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p + ROUND_ONE;
        return s[UF+UW-1:UF];
    endfunction

    plxy_pkg::tag_t         tag_reg [1:NS];
    plxy_pkg::coef_row_t    row_reg [1:4];

    logic [PW-1:0]          s1_vv_reg;
    logic signed [AW-1:0]   s1_cv_reg;
    logic [UW-1:0]          s1_v_reg;
    logic [UW-1:0]          s2_v2_reg;
    logic [UW-1:0]          s2_v_reg;
    logic signed [AW-1:0]   s2_cv_reg;
    logic [PW-1:0]          s3_v2v_reg;
    logic signed [AW-1:0]   s3_c1v2_reg;
    logic signed [AW-1:0]   s3_cv_reg;
    logic [UW-1:0]          s4_v3_reg;
    logic signed [AW-1:0]   s4_part_reg;
    logic signed [AW-1:0]   s5_c0v3_reg;
    logic signed [AW-1:0]   s5_part_reg;
    logic signed [AW-1:0]   s6_acc_reg;
    logic                   s7_neg_reg;
    logic [NQW-1:0]         s7_nq_reg;
    logic [plxy_pkg::PH_W-1:0] s8_ph_reg;
    logic [plxy_pkg::PL_W-1:0] s8_pl_reg;
    logic [RLW-1:0]         s8_nlow_reg;
    logic                   s8_neg_reg;
    logic [QMW-1:0]         s9_qe_reg;
    logic [RLW-1:0]         s9_nlow_reg;
    logic                   s9_neg_reg;
    logic [RLW-1:0]         s10_p_reg;
    logic [QMW-1:0]         s10_qe_reg;
    logic [RLW-1:0]         s10_nlow_reg;
    logic                   s10_neg_reg;
    logic signed [plxy_pkg::Q_W-1:0] s11_q_reg;

    logic signed [CPW-1:0]  cv_prod;
    logic signed [CPW-1:0]  c1v2_prod;
    logic signed [CPW-1:0]  c0v3_prod;
    logic signed [AW-1:0]   c3_ext;
    logic signed [AW-1:0]   n_val;
    logic [plxy_pkg::PH_W-1:0] ph_prod;
    logic [plxy_pkg::PL_W-1:0] pl_prod;
    logic [plxy_pkg::QSUM_W-1:0] qe_sum;
    logic [NQW-1:0]         p_full;
    logic [RLW-1:0]         rem_low;
    logic [QMW-1:0]         q_mag;
    logic signed [plxy_pkg::Q_W-1:0] q_pos;

    assign cv_prod   = plxy_pkg::coef(row, plxy_pkg::COL_LINEAR) * $signed({1'b0, v});
    assign c1v2_prod = plxy_pkg::coef(row_reg[2], plxy_pkg::COL_SQUARE)
                       * $signed({1'b0, s2_v2_reg});
    assign c0v3_prod = plxy_pkg::coef(row_reg[4], plxy_pkg::COL_CUBE)
                       * $signed({1'b0, s4_v3_reg});
    assign c3_ext    = AW'(plxy_pkg::coef(row_reg[3], plxy_pkg::COL_CONST));

    assign n_val   = s6_acc_reg[AW-1] ? (plxy_pkg::HALF_SCALE - s6_acc_reg)
                                      : (s6_acc_reg + plxy_pkg::HALF_SCALE);

    assign ph_prod = s7_nq_reg[NQW-1:LOW] * plxy_pkg::RECIP_M;
    assign pl_prod = s7_nq_reg[LOW-1:0] * plxy_pkg::RECIP_M;
    assign qe_sum  = plxy_pkg::QSUM_W'(s8_ph_reg)
                     + plxy_pkg::QSUM_W'(s8_pl_reg[plxy_pkg::PL_W-1:LOW]);
    assign p_full  = {{(NQW-QMW){1'b0}}, s9_qe_reg}
                     * {{(NQW-plxy_pkg::ODD_W){1'b0}}, plxy_pkg::SCALE_ODD};

    // estimate is low by at most one
    assign rem_low = s10_nlow_reg - s10_p_reg;
    assign q_mag   = s10_qe_reg + QMW'(rem_low >= RLW'(plxy_pkg::SCALE_ODD));
    assign q_pos   = $signed({1'b0, q_mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NS; k++)
                tag_reg[k] <= '0;
        end
        else if (ce)
        begin
            tag_reg[1] <= in_tag;
            for (int k = 2; k <= NS; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            row_reg[1] <= row;
            for (int k = 2; k <= 4; k++)
                row_reg[k] <= row_reg[k-1];

            s1_vv_reg    <= v * v;
            s1_cv_reg    <= cv_prod[AW-1:0];
            s1_v_reg     <= v;

            s2_v2_reg    <= round_q(s1_vv_reg);
            s2_v_reg     <= s1_v_reg;
            s2_cv_reg    <= s1_cv_reg;

            s3_v2v_reg   <= s2_v2_reg * s2_v_reg;
            s3_c1v2_reg  <= c1v2_prod[AW-1:0];
            s3_cv_reg    <= s2_cv_reg;

            s4_v3_reg    <= round_q(s3_v2v_reg);
            s4_part_reg  <= s3_cv_reg + s3_c1v2_reg + (c3_ext <<< UF);

            s5_c0v3_reg  <= c0v3_prod[AW-1:0];
            s5_part_reg  <= s4_part_reg;

            s6_acc_reg   <= s5_c0v3_reg + s5_part_reg;

            s7_neg_reg   <= s6_acc_reg[AW-1];
            s7_nq_reg    <= n_val[NQW+SHIFT-1:SHIFT];

            s8_ph_reg    <= ph_prod;
            s8_pl_reg    <= pl_prod;
            s8_nlow_reg  <= s7_nq_reg[RLW-1:0];
            s8_neg_reg   <= s7_neg_reg;

            s9_qe_reg    <= qe_sum[plxy_pkg::QE_SHIFT+QMW-1:plxy_pkg::QE_SHIFT];
            s9_nlow_reg  <= s8_nlow_reg;
            s9_neg_reg   <= s8_neg_reg;

            s10_p_reg    <= p_full[RLW-1:0];
            s10_qe_reg   <= s9_qe_reg;
            s10_nlow_reg <= s9_nlow_reg;
            s10_neg_reg  <= s9_neg_reg;

            s11_q_reg    <= s10_neg_reg ? -q_pos : q_pos;
        end
    end

    assign out_tag = tag_reg[NS];
    assign q       = s11_q_reg;

endmodule

// File: hw/rtl/planckian_locus_xy.sv
`timescale 1ns / 1ps

// Blackbody locus chromaticity: temperature_kelvin (whole kelvin, values below 1000 K
// taken as 1000 K) goes in, CIE 1931 x_chroma and y_chroma come out as unsigned Q0.16,
// rounded and clamped to 0..65535. One temperature is taken every clock cycle while
// kelvin_ready is high, and a new one can enter while earlier ones are still in flight.
// The data path has 49 register stages: the 26-stage reciprocal divider (an input
// register, then one quotient bit per stage), two 11-stage cubic evaluators and the
// output register. When chroma_ready is low the pipeline keeps running until the output
// register and its one-entry skid are full, then holds.
module planckian_locus_xy (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                kelvin_valid,
    output logic                                kelvin_ready,
    input  logic [plxy_pkg::TEMP_W-1:0]         temperature_kelvin,
    output logic                                chroma_valid,
    input  logic                                chroma_ready,
    output logic [plxy_pkg::COORD_W-1:0]        x_chroma,
    output logic [plxy_pkg::COORD_W-1:0]        y_chroma
);

    localparam int NS = plxy_pkg::CUBIC_STAGES;
    localparam int CW = plxy_pkg::COORD_W;

    logic                               ce;
    plxy_pkg::tag_t                     u_tag;
    logic [plxy_pkg::U_W-1:0]           u;
    plxy_pkg::tag_t                     x_tag;
    logic signed [plxy_pkg::Q_W-1:0]    x_q;
    plxy_pkg::tag_t                     y_tag;
    logic signed [plxy_pkg::Q_W-1:0]    y_q;
    plxy_pkg::coef_row_t                x_row;
    plxy_pkg::coef_row_t                y_row;

    logic signed [plxy_pkg::Q_W-1:0]    xq_reg [1:NS];

    logic               chroma_valid_reg;
    logic               chroma_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [CW-1:0]      x_out_reg;
    logic [CW-1:0]      y_out_reg;
    logic [CW-1:0]      x_skid_reg;
    logic [CW-1:0]      y_skid_reg;
    logic [CW-1:0]      x_new;
    logic [CW-1:0]      y_new;
    logic               push;
    logic               pop;
    logic               load_out;
    logic               load_skid;
    logic               out_from_skid;

    assign ce           = !skid_valid_reg;
    assign kelvin_ready = ce;

    plxy_recip u_recip (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .in_valid    (kelvin_valid),
        .temperature (temperature_kelvin),
        .out_tag     (u_tag),
        .u           (u)
    );

    assign x_row = u_tag.below_x_split ? plxy_pkg::ROW_XA : plxy_pkg::ROW_XB;

    plxy_cubic u_cubic_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_tag  (u_tag),
        .row     (x_row),
        .v       (u),
        .out_tag (x_tag),
        .q       (x_q)
    );

    always_comb
    begin
        if (x_tag.below_y_split)
            y_row = plxy_pkg::ROW_YA;
        else if (x_tag.below_x_split)
            y_row = plxy_pkg::ROW_YB;
        else
            y_row = plxy_pkg::ROW_YC;
    end

    // x stays well inside 0..1, so its low bits feed the second cubic directly
    plxy_cubic u_cubic_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .in_tag  (x_tag),
        .row     (y_row),
        .v       (x_q[plxy_pkg::U_W-1:0]),
        .out_tag (y_tag),
        .q       (y_q)
    );

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            xq_reg[1] <= x_q;
            for (int k = 2; k <= NS; k++)
                xq_reg[k] <= xq_reg[k-1];
        end
    end

    assign x_new = plxy_pkg::to_coord(xq_reg[NS]);
    assign y_new = plxy_pkg::to_coord(y_q);

    assign push = ce && y_tag.valid;
    assign pop  = chroma_valid_reg && chroma_ready;

    always_comb
    begin
        chroma_valid_next = chroma_valid_reg;
        skid_valid_next   = skid_valid_reg;
        load_out          = 1'b0;
        load_skid         = 1'b0;
        out_from_skid     = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!chroma_valid_reg || pop)
            begin
                load_out          = 1'b1;
                chroma_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            chroma_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            chroma_valid_reg <= chroma_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            x_out_reg <= x_skid_reg;
            y_out_reg <= y_skid_reg;
        end
        else if (load_out)
        begin
            x_out_reg <= x_new;
            y_out_reg <= y_new;
        end
        if (load_skid)
        begin
            x_skid_reg <= x_new;
            y_skid_reg <= y_new;
        end
    end

    assign chroma_valid = chroma_valid_reg;
    assign x_chroma     = x_out_reg;
    assign y_chroma     = y_out_reg;

endmodule
